// File: hw/rtl/hsadq_pkg.sv
// Package for the hash set block: sizes, operation codes, sequencer states
// and the slot store request struct. No dependencies.
`default_nettype none

package hsadq_pkg;

  // Set geometry
  localparam int BUCKETS = 256;
  localparam int WAYS    = 4;
  localparam int SLOTS   = BUCKETS * WAYS;

  localparam int KEY_W  = 64;
  localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W  = $clog2(WAYS + 1);
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Bucket count a power of two: the modulo is a mask
  localparam bit BKT_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  // Operation codes; anything else behaves as a query
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  // Access request to the slot store
  typedef struct packed {
    logic              key_re;
    logic              key_we;
    logic [ADDR_W-1:0] key_addr;
    logic [KEY_W-1:0]  key_wdata;
    logic              row_re;
    logic              row_we;
    logic [BKT_W-1:0]  row_addr;
    logic [WAYS-1:0]   row_wdata;
  } slot_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/hsadq_mod.sv
// Bucket index unit: magnitude of the key modulo BUCKETS.
// Mask for a power-of-two bucket count, else 16-bit key chunks folded in
// through one shared multiplier, three steps a chunk. Depends on hsadq_pkg.
`default_nettype none

module hsadq_mod
  import hsadq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [KEY_W-1:0] key,
  output logic                  done,
  output logic [BKT_W-1:0]      bucket
);

  // Two's complement magnitude; the most negative key stays 2^63
  logic [KEY_W-1:0] mag;
  assign mag = key[KEY_W-1] ? (KEY_W'(0) - key) : key;

  if (BKT_POW2) begin : g_mask
    localparam logic [KEY_W-1:0] MASK = KEY_W'(BUCKETS - 1);
    logic [BKT_W-1:0] rem;

    always_ff @(posedge clk) begin
      if (rst) begin
        done <= 1'b0;
      end else begin
        done <= start;
      end
      if (start) begin
        rem <= BKT_W'(mag & MASK);
      end
    end

    assign bucket = rem;
  end else begin : g_recip
    // Not a power of two; with BUCKETS at most 65535 remainders fit 16 bits.
    // Per chunk, high first: rem = (rem * 2^16 + chunk) mod BUCKETS, with the
    // quotient estimated by a reciprocal product (low by at most one).
    localparam logic [15:0] DIVISOR = 16'(BUCKETS);
    localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / 64'(BUCKETS));
    localparam logic [1:0]  LAST    = 2'd3;
    localparam logic [1:0]  PH_EST  = 2'd0;
    localparam logic [1:0]  PH_SUB  = 2'd1;
    localparam logic [1:0]  PH_FIX  = 2'd2;

    logic             busy;
    logic [1:0]       phase;
    logic [1:0]       chunk;
    logic [KEY_W-1:0] sh;
    logic [15:0]      rem;
    logic [31:0]      acc;
    logic [15:0]      quo;
    logic [16:0]      est;
    logic [31:0]      acc_in;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      prod;

    // Shared multiplier: reciprocal product, then quotient times divisor
    always_comb begin
      acc_in = {rem, sh[KEY_W-1 -: 16]};
      if (phase == PH_EST) begin
        mul_a = acc_in;
        mul_b = RECIP;
      end else begin
        mul_a = {16'd0, quo};
        mul_b = {16'd0, DIVISOR};
      end
      prod = 64'(mul_a) * 64'(mul_b);
    end

    // Sequencer: three phases per chunk, four chunks
    always_ff @(posedge clk) begin
      if (rst) begin
        busy  <= 1'b0;
        done  <= 1'b0;
        phase <= PH_EST;
        chunk <= '0;
      end else begin
        done <= 1'b0;
        if (start) begin
          busy  <= 1'b1;
          phase <= PH_EST;
          chunk <= '0;
        end else if (busy) begin
          if (phase == PH_FIX) begin
            phase <= PH_EST;
            chunk <= chunk + 2'd1;
            if (chunk == LAST) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end else begin
            phase <= phase + 2'd1;
          end
        end
      end
      if (start) begin
        sh  <= mag;
        rem <= '0;
      end else if (busy) begin
        case (phase)
          PH_EST: begin
            acc <= acc_in;
            quo <= prod[47:32];
          end
          PH_SUB: begin
            est <= 17'(acc - prod[31:0]);
          end
          default: begin
            rem <= (est >= {1'b0, DIVISOR}) ? 16'(est - {1'b0, DIVISOR}) : est[15:0];
            sh  <= {sh[KEY_W-17:0], 16'd0};
          end
        endcase
      end
    end

    assign bucket = rem[BKT_W-1:0];
  end

endmodule

`default_nettype wire

// File: hw/rtl/hsadq_slots.sv
// Slot store: key memory (one entry per slot) and valid row memory
// (one row of WAYS bits per bucket), registered reads. Depends on hsadq_pkg.
`default_nettype none

module hsadq_slots
  import hsadq_pkg::*;
(
  input  wire logic       clk,
  input  wire slot_req_t  req,
  output logic [KEY_W-1:0] key_rdata,
  output logic [WAYS-1:0]  row_rdata
);

  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [WAYS-1:0]  row_mem [BUCKETS];

  // Key memory
  always_ff @(posedge clk) begin
    if (req.key_we) begin
      key_mem[req.key_addr] <= req.key_wdata;
    end
    if (req.key_re) begin
      key_rdata <= key_mem[req.key_addr];
    end
  end

  // Valid rows
  always_ff @(posedge clk) begin
    if (req.row_we) begin
      row_mem[req.row_addr] <= req.row_wdata;
    end
    if (req.row_re) begin
      row_rdata <= row_mem[req.row_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/hash_set_add_delete_query.sv
// Hash set of signed 64-bit keys, BUCKETS buckets of WAYS slots each.
// After reset a clearing pass writes every valid row, one bucket a cycle,
// with req_stall high. Then an item is accepted, its bucket index is formed
// (four 16-bit key chunks, three steps each through one multiplier, when
// BUCKETS is not a power of two), the bucket is walked through the single
// key comparator behind the registered key memory read, and the write-back
// and result register load follow, held while the result register is full
// and stalled. The result register lets the next item in while a result
// still waits on rsp_stall.
// Depends on hsadq_pkg, hsadq_mod, hsadq_slots.
`default_nettype none

module hash_set_add_delete_query
  import hsadq_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    req_valid,
  output logic                         req_stall,
  input  wire logic [1:0]              operation,
  input  wire logic signed [KEY_W-1:0] key,
  output logic                         rsp_valid,
  input  wire logic                    rsp_stall,
  output logic                         was_present,
  output logic                         status
);

  state_t state, state_next;

  logic [CNT_W-1:0] cnt;
  logic [BKT_W-1:0] clr_cnt;
  logic [1:0]       op_q;
  logic [KEY_W-1:0] key_q;
  logic             hit_found;
  logic [WAY_W-1:0] hit_way;
  logic             free_found;
  logic [WAY_W-1:0] free_way;

  logic             accept;
  logic             out_free;
  logic             mod_done;
  logic [BKT_W-1:0] bucket;
  logic [ADDR_W-1:0] base;
  logic [CNT_W-1:0] cnt_m1;
  logic [WAY_W-1:0] cmp_way;
  logic             cmp_en;
  logic             way_valid;
  logic             key_eq;
  logic             do_add;
  logic             add_full;

  slot_req_t        sreq;
  logic [KEY_W-1:0] key_rdata;
  logic [WAYS-1:0]  row_rdata;

  assign accept   = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;

  hsadq_mod u_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .key    (key),
    .done   (mod_done),
    .bucket (bucket)
  );

  hsadq_slots u_slots (
    .clk       (clk),
    .req       (sreq),
    .key_rdata (key_rdata),
    .row_rdata (row_rdata)
  );

  // Scan bookkeeping: way whose key is on the read port, shared compare
  assign base      = ADDR_W'(ADDR_W'(bucket) * ADDR_W'(WAYS));
  assign cnt_m1    = cnt - CNT_W'(1);
  assign cmp_way   = cnt_m1[WAY_W-1:0];
  assign cmp_en    = (state == ST_SCAN) && (cnt != '0);
  assign way_valid = row_rdata[cmp_way];
  assign key_eq    = (key_rdata == key_q);

  // Outcome of the scan
  assign do_add   = (op_q == OP_ADD) && !hit_found && free_found;
  assign add_full = (op_q == OP_ADD) && !hit_found && !free_found;

  // Sequencer: next state, stall, store requests
  always_comb begin
    state_next     = state;
    req_stall      = 1'b1;
    sreq           = '0;
    sreq.key_addr  = base + ADDR_W'(cnt[WAY_W-1:0]);
    sreq.key_wdata = key_q;
    sreq.row_addr  = bucket;
    sreq.row_wdata = row_rdata;
    unique case (state)
      ST_CLEAR: begin
        sreq.row_we    = 1'b1;
        sreq.row_addr  = clr_cnt;
        sreq.row_wdata = '0;
        if (clr_cnt == BKT_W'(BUCKETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          state_next = ST_HASH;
        end
      end
      ST_HASH: begin
        if (mod_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt != CNT_W'(WAYS)) begin
          sreq.key_re = 1'b1;
          sreq.row_re = (cnt == '0);
        end else begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_next = ST_IDLE;
          if (do_add) begin
            sreq.key_we    = 1'b1;
            sreq.key_addr  = base + ADDR_W'(free_way);
            sreq.row_we    = 1'b1;
            sreq.row_wdata = row_rdata | (WAYS'(1) << free_way);
          end else if (op_q == OP_DELETE && hit_found) begin
            sreq.row_we    = 1'b1;
            sreq.row_wdata = row_rdata & ~(WAYS'(1) << hit_way);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      cnt     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + BKT_W'(1);
      end
      if (state == ST_SCAN) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  // Item capture and per-way hit / free tracking
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= operation;
      key_q      <= key;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      hit_way    <= '0;
      free_way   <= '0;
    end else if (cmp_en) begin
      if (way_valid && key_eq && !hit_found) begin
        hit_found <= 1'b1;
        hit_way   <= cmp_way;
      end
      if (!way_valid && !free_found) begin
        free_found <= 1'b1;
        free_way   <= cmp_way;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_UPDATE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (state == ST_UPDATE && out_free) begin
      was_present <= hit_found;
      status      <= add_full;
    end
  end

endmodule

`default_nettype wire
